>>> hdl/nms_pkg.sv
// Package for the Nixie multiplex scanner: shared constants, register indexes
// and the structs that pass between the front end, the queue and the scan engine.
// No dependencies.
package nms_pkg;

    localparam int TUBE_COUNT_DEF  = 8;
    localparam int ANODE_COUNT_DEF = 4;
    localparam int QUEUE_DEPTH     = 4;

    localparam int CODE_W    = 5;
    localparam int PULSE_W   = 16;
    localparam int DUTY_W    = 9;
    localparam int ANODE_W   = 4;
    localparam int INDEX_W   = 3;
    localparam int CHAR_W    = 8;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CODE_W-1:0]  BLANK_CODE  = 5'd15;
    localparam logic [CODE_W-1:0]  DOT_CODE    = 5'd31;
    localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd100;
    localparam logic [DUTY_W-1:0]  DUTY_ONE    = 9'd256;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

    // Item kinds on the input tuser bit.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_TICKS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_DUTY_Q8     = 1'b1;

    // A classified word as it waits in the queue.
    typedef struct packed {
        logic               is_write;
        logic [INDEX_W-1:0] tube_index;
        logic [CODE_W-1:0]  code;
    } nms_item_t;

    // One configuration write.
    typedef struct packed {
        logic                  en;
        logic [CFG_ADDR_W-1:0] addr;
        logic [PULSE_W-1:0]    data;
    } nms_cfg_t;

    // One result word.
    typedef struct packed {
        logic [CODE_W-1:0]  cathode_high_group;
        logic [CODE_W-1:0]  cathode_low_group;
        logic [ANODE_W-1:0] anode_enable;
    } nms_result_t;

endpackage

>>> hdl/nms_front.sv
// Front end of the Nixie multiplex scanner: classifies each accepted word and
// decodes a character into its 5-bit cathode code. Depends on nms_pkg.
module nms_front (
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        operation,
    input  logic [nms_pkg::INDEX_W-1:0] tube_index,
    input  logic [nms_pkg::CHAR_W-1:0]  char_code,
    output logic                        push,
    output nms_pkg::nms_item_t          item
);

    logic [nms_pkg::CODE_W-1:0] code;

    // Digits map to their binary value, which is simply the low nibble.
    always_comb begin
        if (char_code >= nms_pkg::CHAR_ZERO && char_code <= nms_pkg::CHAR_NINE) begin
            code = {1'b0, char_code[3:0]};
        end else if (char_code == nms_pkg::CHAR_DOT) begin
            code = nms_pkg::DOT_CODE;
        end else begin
            code = nms_pkg::BLANK_CODE;
        end
    end

    assign push            = in_valid && in_ready;
    assign item.is_write   = (operation == nms_pkg::OP_WRITE);
    assign item.tube_index = tube_index;
    assign item.code       = code;

endmodule

>>> hdl/nms_queue.sv
// Short queue between the front end and the scan engine of the Nixie
// multiplex scanner. Depends on nms_pkg for the item type and depth.
module nms_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  nms_pkg::nms_item_t push_item,
    output logic               not_full,
    input  logic               pop,
    output logic               not_empty,
    output nms_pkg::nms_item_t head_item
);

    localparam int DEPTH = nms_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nms_pkg::nms_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/nms_back.sv
// Scan engine of the Nixie multiplex scanner: configuration registers, tube
// code store, phase sequencer and the output register. Depends on nms_pkg.
module nms_back #(
    parameter int TUBE_COUNT  = nms_pkg::TUBE_COUNT_DEF,
    parameter int ANODE_COUNT = nms_pkg::ANODE_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  nms_pkg::nms_cfg_t   cfg,
    input  logic                item_valid,
    input  nms_pkg::nms_item_t  item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output nms_pkg::nms_result_t out_word
);

    localparam int SCAN_W  = (ANODE_COUNT > 1) ? $clog2(ANODE_COUNT) : 1;
    localparam int PULSE_W = nms_pkg::PULSE_W;
    localparam int DUTY_W  = nms_pkg::DUTY_W;
    localparam int CODE_W  = nms_pkg::CODE_W;
    localparam int PROD_W  = PULSE_W + DUTY_W;

    logic [PULSE_W-1:0] pulse_reg, pulse_next;
    logic [DUTY_W-1:0]  duty_reg,  duty_next;
    logic [PULSE_W-1:0] on_len_reg, off_len_reg;
    logic [PROD_W-1:0]  product;
    logic [PULSE_W-1:0] on_len_calc;

    logic [CODE_W-1:0] low_codes_reg  [ANODE_COUNT];
    logic [CODE_W-1:0] high_codes_reg [ANODE_COUNT];
    logic [CODE_W-1:0] low_codes_next [ANODE_COUNT];
    logic [CODE_W-1:0] high_codes_next[ANODE_COUNT];

    logic               in_on_reg, in_on_next;
    logic [SCAN_W-1:0]  scan_reg, scan_next;
    logic [PULSE_W-1:0] ticks_reg, ticks_next;

    logic               out_valid_reg, out_valid_next;
    nms_pkg::nms_result_t out_word_reg, out_word_next;

    logic               is_tick;
    logic               adv1, adv2, p1_on, p2_on;
    logic [SCAN_W-1:0]  p1_scan, p2_scan;
    logic [PULSE_W-1:0] len_cur, len_p1;
    logic               show_on;
    logic [SCAN_W-1:0]  show_scan;

    function automatic logic [SCAN_W-1:0] scan_inc(input logic [SCAN_W-1:0] s);
        if (s == SCAN_W'(ANODE_COUNT - 1)) begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    // Configuration writes; illegal values leave the register as it was.
    always_comb begin
        pulse_next = pulse_reg;
        duty_next  = duty_reg;
        if (cfg.en) begin
            case (cfg.addr)
                nms_pkg::REG_PULSE_TICKS: begin
                    if (cfg.data != '0) begin
                        pulse_next = cfg.data;
                    end
                end
                nms_pkg::REG_DUTY_Q8: begin
                    if (cfg.data[DUTY_W-1:0] != '0 &&
                        cfg.data[DUTY_W-1:0] <= nms_pkg::DUTY_ONE) begin
                        duty_next = cfg.data[DUTY_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Phase lengths are registered from the configuration registers.
    assign product     = PROD_W'(pulse_reg) * PROD_W'(duty_reg);
    assign on_len_calc = product[PULSE_W+7:8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg   <= nms_pkg::PULSE_RESET;
            duty_reg    <= nms_pkg::DUTY_ONE;
            on_len_reg  <= nms_pkg::PULSE_RESET;
            off_len_reg <= '0;
        end else begin
            pulse_reg   <= pulse_next;
            duty_reg    <= duty_next;
            on_len_reg  <= on_len_calc;
            off_len_reg <= pulse_reg - on_len_calc;
        end
    end

    assign pop     = item_valid && (!out_valid_reg || out_ready);
    assign is_tick = !item.is_write;

    // Tube store, split so that each bank is read at the scan index only.
    always_comb begin
        for (int j = 0; j < ANODE_COUNT; j++) begin
            low_codes_next[j]  = low_codes_reg[j];
            high_codes_next[j] = high_codes_reg[j];
            if (pop && item.is_write) begin
                if (j < TUBE_COUNT && int'(item.tube_index) == j) begin
                    low_codes_next[j] = item.code;
                end
                if (j + ANODE_COUNT < TUBE_COUNT &&
                    int'(item.tube_index) == j + ANODE_COUNT) begin
                    high_codes_next[j] = item.code;
                end
            end
        end
    end

    // Up to two phase changes per tick; only one of on and off can be empty.
    always_comb begin
        len_cur = in_on_reg ? on_len_reg : off_len_reg;
        adv1    = (ticks_reg >= len_cur);
        p1_on   = adv1 ? !in_on_reg : in_on_reg;
        p1_scan = (adv1 && !in_on_reg) ? scan_inc(scan_reg) : scan_reg;
        len_p1  = p1_on ? on_len_reg : off_len_reg;
        adv2    = adv1 && (len_p1 == '0);
        p2_on   = adv2 ? !p1_on : p1_on;
        p2_scan = (adv2 && !p1_on) ? scan_inc(p1_scan) : p1_scan;

        in_on_next = in_on_reg;
        scan_next  = scan_reg;
        ticks_next = ticks_reg;
        if (pop && is_tick) begin
            in_on_next = p2_on;
            scan_next  = p2_scan;
            ticks_next = adv1 ? PULSE_W'(1) : ticks_reg + 1'b1;
        end

        show_on   = (pop && is_tick) ? p2_on : in_on_reg;
        show_scan = (pop && is_tick) ? p2_scan : scan_reg;
    end

    always_comb begin
        out_word_next = out_word_reg;
        if (pop) begin
            for (int a = 0; a < nms_pkg::ANODE_W; a++) begin
                out_word_next.anode_enable[a] = show_on && (int'(show_scan) == a);
            end
            out_word_next.cathode_low_group  = low_codes_next[show_scan];
            out_word_next.cathode_high_group = high_codes_next[show_scan];
        end
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_on_reg     <= 1'b1;
            scan_reg      <= '0;
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < ANODE_COUNT; j++) begin
                low_codes_reg[j]  <= nms_pkg::BLANK_CODE;
                high_codes_reg[j] <= nms_pkg::BLANK_CODE;
            end
        end else begin
            in_on_reg     <= in_on_next;
            scan_reg      <= scan_next;
            ticks_reg     <= ticks_next;
            out_valid_reg <= out_valid_next;
            for (int j = 0; j < ANODE_COUNT; j++) begin
                low_codes_reg[j]  <= low_codes_next[j];
                high_codes_reg[j] <= high_codes_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> hdl/nixie_multiplex_scanner.sv
// Top level of the Nixie multiplex scanner: stream ports, configuration port
// and the front end, queue and scan engine. Depends on nms_pkg and the nms_ modules.
//
// This block scans eight Nixie tubes that share four anodes and two cathode groups.
// Every input word is either a tick, which advances the scan by one tick, or a
// write, which stores one tube's character as a 5-bit cathode code ('0' to '9'
// in binary, '.' as 31, anything else as the blank code 15). Every word gives
// exactly one result word, showing the anode drive of the current phase and the
// codes of tube i and tube i plus the anode count. Words are taken at one per
// clock cycle for as long as results are taken at the same pace; an accepted
// word is registered first into the four-deep queue and then into the output
// register. The queue is four words deep, so while the output side is stalled
// the input side keeps accepting until four words wait behind the held result
// word. The on length is recomputed from the pulse and duty registers through
// a single 16 by 9 bit multiplier and is registered after those registers take
// a configuration write; as every word passes through the queue before it is
// carried out, the new lengths are in place before any word accepted after the
// write is carried out. Writes of illegal values (zero pulse, duty whose low
// nine bits are zero or above 256) are ignored.
module nixie_multiplex_scanner #(
    parameter int TUBE_COUNT  = nms_pkg::TUBE_COUNT_DEF,
    parameter int ANODE_COUNT = nms_pkg::ANODE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] tube_index, [10:3] char_code, rest zero
    input  logic [0:0]  s_tuser,   // [0] operation: 0 tick, 1 write
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] anode_enable, [8:4] cathode_low_group,
                                   // [13:9] cathode_high_group, rest zero
    // Configuration: index 0 pulse_ticks, index 1 duty_q8.
    input  logic                              cfg_wr_en,
    input  logic [nms_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [nms_pkg::PULSE_W-1:0]       cfg_wdata
);

    logic                 push;
    logic                 pop;
    logic                 q_not_full;
    logic                 q_not_empty;
    nms_pkg::nms_item_t   push_item;
    nms_pkg::nms_item_t   head_item;
    nms_pkg::nms_cfg_t    cfg;
    nms_pkg::nms_result_t result;

    assign cfg.en   = cfg_wr_en;
    assign cfg.addr = cfg_addr;
    assign cfg.data = cfg_wdata;

    assign s_tready = q_not_full;

    // The front end classifies the word and decodes the character.
    nms_front u_front (
        .in_valid   (s_tvalid),
        .in_ready   (q_not_full),
        .operation  (s_tuser[0]),
        .tube_index (s_tdata[2:0]),
        .char_code  (s_tdata[10:3]),
        .push       (push),
        .item       (push_item)
    );

    nms_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // The scan engine carries out one queued word per cycle while its result word is not held by the output side.
    nms_back #(
        .TUBE_COUNT  (TUBE_COUNT),
        .ANODE_COUNT (ANODE_COUNT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (q_not_empty),
        .item       (head_item),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_word   (result)
    );

    assign m_tdata = {2'b00, result};

endmodule

>>> hdl/nms_checker.sv
// Port-level checker for the Nixie multiplex scanner, bound to the top level.
// Depends only on the top level's ports.
module nms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // At most one anode is driven in any valid result word.
    a_anode_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[3:0]))
        else $error("more than one anode driven");

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The input side only stops when the output side has been stalled.
    a_ready_back: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word present after reset");

endmodule

bind nixie_multiplex_scanner nms_checker u_nms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
